>>> hdl/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes of the round-robin task scheduler: request and
// response payloads, event and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package rrts_pkg;

   // field widths of the request and response payloads
   localparam int MODE_W   = 3;
   localparam int ADDR_W   = 21;
   localparam int ID_W     = 4;
   localparam int WORK_W   = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 32;
   localparam int QLEN_W   = 5;

   // event codes
   localparam logic [MODE_W-1:0] MODE_LOAD     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_KILL     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_QUANTUM  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RETIRE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DISPATCH = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd4;

   // slot states
   localparam logic [1:0] SLOT_FREE    = 2'd0;
   localparam logic [1:0] SLOT_FRESH   = 2'd1;
   localparam logic [1:0] SLOT_STARTED = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [ADDR_W-1:0] address;
      logic [ID_W-1:0]   task_id;
      logic [WORK_W-1:0] work_byte;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                run_valid;
      logic [ID_W-1:0]     run_slot;
      logic [ADDR_W-1:0]   run_address;
      logic                run_resume;
      logic [WORK_W-1:0]   run_work_byte;
      logic [COUNT_W-1:0]  run_count;
      logic [QLEN_W-1:0]   queue_length;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_WALK,
      ST_SLOT,
      ST_REPLY
   } ctrl_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic scan_init;
      logic scan_step;
      logic walk_init;
      logic walk_step;
      logic commit;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              q_empty;
      logic              kill_hit;
      logic              scan_last;
      logic              walk_done;
      logic              out_free;
   } dp_status_type;

endpackage

>>> hdl/round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Task slot table with a round-robin ready queue: load, kill, quantum expiry,
// retire and dispatch events, one response per request.
//
//   channel  direction  handshake               payload
//   req_     in         req_valid / req_ready   rrts_pkg::req_type
//   rsp_     out        rsp_valid / rsp_ready   rrts_pkg::rsp_type
//
// A load steps through the slot table one slot per cycle, and a kill of a
// queued task walks the queue memory one queue entry per cycle.
// One request at a time; the next request can be taken in the cycle after
// the previous result enters the response register, even while it still waits.
// A waiting response stalls completion of the next request until taken.
// Reset empties the queue and frees all slots.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler #(
   parameter int SLOTS       = 16,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rrts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rrts_pkg::rsp_type rsp_data
);
   import rrts_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   // event sequencer
   rrts_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot table, queue and response register
   rrts_datapath #(
      .SLOTS       (SLOTS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hdl/rrts_control.sv
// ----------------------------------------------------------------------------
// rrts_control
// Event sequencer: takes a request, steps the datapath through the slot scan,
// the queue walk or the head reads, and commits when the response register
// is free.
// ----------------------------------------------------------------------------
module rrts_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rrts_pkg::dp_status_type sts,
   output rrts_pkg::dp_cmd_type   cmd
);
   import rrts_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.mode)
               MODE_LOAD: begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN;
               end
               MODE_KILL: begin
                  cmd.walk_init = sts.kill_hit;
                  state_in      = sts.kill_hit ? ST_WALK : ST_REPLY;
               end
               MODE_DISPATCH: begin
                  state_in = sts.q_empty ? ST_REPLY : ST_SLOT;
               end
               default: begin
                  state_in = ST_REPLY;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_REPLY;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (sts.walk_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_SLOT: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            // hold until the response register can take the result
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/rrts_datapath.sv
// ----------------------------------------------------------------------------
// rrts_datapath
// Slot table, ready queue and response register of the scheduler. The queue
// is a circular buffer; the slot fields live in small memories with
// registered reads, the slot states in flops that reset clears.
// ----------------------------------------------------------------------------
module rrts_datapath #(
   parameter int SLOTS       = 16,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rrts_pkg::req_type       req_data,
   input  rrts_pkg::dp_cmd_type    cmd,
   output rrts_pkg::dp_status_type sts,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output rrts_pkg::rsp_type       rsp_data
);
   import rrts_pkg::*;

   localparam int SW = $clog2(SLOTS);
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = (SW > ID_W) ? SW : ID_W;

   function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
      ptr_inc = (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [QW-1:0] ptr_dec(input logic [QW-1:0] p);
      ptr_dec = (p == '0) ? QW'(QUEUE_DEPTH - 1) : p - 1'b1;
   endfunction

   // request register
   req_type req_ff;

   // slot table
   logic [1:0]         slot_state_ff [SLOTS];
   logic [ADDR_W-1:0]  start_mem     [SLOTS];
   logic [ADDR_W-1:0]  resume_mem    [SLOTS];
   logic [WORK_W-1:0]  work_mem      [SLOTS];
   logic [COUNT_W-1:0] cnt_mem       [SLOTS];
   logic [ADDR_W-1:0]  start_rd_ff;
   logic [ADDR_W-1:0]  resume_rd_ff;
   logic [WORK_W-1:0]  work_rd_ff;
   logic [COUNT_W-1:0] cnt_rd_ff;
   logic [SW-1:0]      s_rd_addr;
   logic [SW-1:0]      s_wr_addr;

   // ready queue
   logic [SW-1:0] queue_mem [QUEUE_DEPTH];
   logic [SW-1:0] q_rd_data_ff;
   logic [QW-1:0] q_rd_addr;
   logic          q_we;
   logic [QW-1:0] q_wr_addr;
   logic [SW-1:0] q_wr_data;
   logic [QW-1:0] head_ff;
   logic [QW-1:0] head_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW:0]   tail_sum;
   logic [QW-1:0] tail_ptr;
   logic [SW-1:0] head_slot;

   // load scan
   logic [SW-1:0] sc_ff;
   logic          cmp_vld_ff;
   logic          dup_ff;
   logic          dup_now;
   logic          free_found_ff;
   logic [SW-1:0] free_slot_ff;

   // kill walk
   logic [QW-1:0] wk_ptr_ff;
   logic [CW-1:0] wk_left_ff;
   logic          chk_vld_ff;
   logic [QW-1:0] chk_ptr_ff;
   logic          found_ff;
   logic          chk_match;
   logic          shift_we;

   // event evaluation
   logic [IW-1:0]       id_ext;
   logic [SW-1:0]       id_slot;
   logic                kill_hit;
   logic                q_empty;
   logic                q_full;
   logic [STATUS_W-1:0] status_val;
   logic                ok_apply;
   logic                do_apply;
   logic [COUNT_W-1:0]  cnt_next;
   logic                head_fresh;
   rsp_type             rsp_in;
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;

   // capture the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
   end

   assign head_slot  = q_rd_data_ff;
   assign id_ext     = IW'(req_ff.task_id);
   assign id_slot    = id_ext[SW-1:0];
   assign kill_hit   = (id_ext != '0) && ({1'b0, id_ext} < (IW + 1)'(SLOTS)) &&
                       (slot_state_ff[id_slot] != SLOT_FREE);
   assign q_empty    = (count_ff == '0);
   assign q_full     = (count_ff >= CW'(QUEUE_DEPTH));
   assign head_fresh = (slot_state_ff[head_slot] == SLOT_FRESH);

   // tail position: head plus count, wrapped once
   assign tail_sum = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign tail_ptr = (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) ?
                     QW'(tail_sum - (CW + 1)'(QUEUE_DEPTH)) : QW'(tail_sum);

   // queue memory: walk pointer while walking, head otherwise
   assign q_rd_addr = cmd.walk_step ? wk_ptr_ff : head_ff;

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[q_wr_addr] <= q_wr_data;
      end
      q_rd_data_ff <= queue_mem[q_rd_addr];
   end

   // slot memories: scan index while scanning, head slot otherwise
   assign s_rd_addr = cmd.scan_step ? sc_ff : head_slot;
   assign s_wr_addr = (req_ff.mode == MODE_LOAD) ? free_slot_ff : head_slot;

   always_ff @(posedge clock) begin
      if (do_apply) begin
         case (req_ff.mode)
            MODE_LOAD: begin
               start_mem[s_wr_addr]  <= req_ff.address;
               resume_mem[s_wr_addr] <= req_ff.address;
               work_mem[s_wr_addr]   <= '0;
               cnt_mem[s_wr_addr]    <= '0;
            end
            MODE_QUANTUM: begin
               resume_mem[s_wr_addr] <= req_ff.address;
               work_mem[s_wr_addr]   <= req_ff.work_byte;
            end
            MODE_DISPATCH: begin
               cnt_mem[s_wr_addr] <= cnt_next;
            end
            default: begin
            end
         endcase
      end
      start_rd_ff  <= start_mem[s_rd_addr];
      resume_rd_ff <= resume_mem[s_rd_addr];
      work_rd_ff   <= work_mem[s_rd_addr];
      cnt_rd_ff    <= cnt_mem[s_rd_addr];
   end

   // slot states
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_state_ff[i] <= SLOT_FREE;
         end
      end else if (do_apply) begin
         case (req_ff.mode)
            MODE_LOAD: begin
               slot_state_ff[free_slot_ff] <= SLOT_FRESH;
            end
            MODE_KILL: begin
               slot_state_ff[id_slot] <= SLOT_FREE;
            end
            MODE_RETIRE: begin
               slot_state_ff[head_slot] <= SLOT_FREE;
            end
            MODE_DISPATCH: begin
               if (head_fresh) begin
                  slot_state_ff[head_slot] <= SLOT_STARTED;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // load scan: duplicate address among live slots, first free slot from 1
   assign dup_now = dup_ff | (cmp_vld_ff && (start_rd_ff == req_ff.address));

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_ff         <= '0;
         cmp_vld_ff    <= 1'b0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (cmd.scan_init) begin
         sc_ff         <= SW'(1);
         cmp_vld_ff    <= 1'b0;
         dup_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan_step && (slot_state_ff[sc_ff] != SLOT_FREE);
         dup_ff     <= dup_now;
         if (cmd.scan_step) begin
            sc_ff <= sc_ff + 1'b1;
            if (slot_state_ff[sc_ff] == SLOT_FREE && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && slot_state_ff[sc_ff] == SLOT_FREE && !free_found_ff) begin
         free_slot_ff <= sc_ff;
      end
   end

   // kill walk: find the id, then pull each later entry forward by one
   assign chk_match = (IW'(q_rd_data_ff) == id_ext);
   assign shift_we  = cmd.walk_step && chk_vld_ff && !chk_match && found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wk_left_ff <= '0;
         chk_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else if (cmd.walk_init) begin
         wk_left_ff <= count_ff;
         chk_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
      end else if (cmd.walk_step) begin
         chk_vld_ff <= (wk_left_ff != '0);
         if (wk_left_ff != '0) begin
            wk_left_ff <= wk_left_ff - 1'b1;
         end
         if (chk_vld_ff && chk_match) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         wk_ptr_ff <= head_ff;
      end else if (cmd.walk_step && wk_left_ff != '0) begin
         wk_ptr_ff  <= ptr_inc(wk_ptr_ff);
         chk_ptr_ff <= wk_ptr_ff;
      end
   end

   // queue write port: walk shifts, or tail append on load and rotation
   always_comb begin
      q_we      = 1'b0;
      q_wr_addr = tail_ptr;
      q_wr_data = head_slot;
      if (shift_we) begin
         q_we      = 1'b1;
         q_wr_addr = ptr_dec(chk_ptr_ff);
         q_wr_data = q_rd_data_ff;
      end else if (do_apply && req_ff.mode == MODE_LOAD) begin
         q_we      = 1'b1;
         q_wr_data = free_slot_ff;
      end else if (do_apply && req_ff.mode == MODE_QUANTUM) begin
         q_we      = 1'b1;
      end
   end

   // evaluate the event
   always_comb begin
      status_val = STATUS_OK;
      ok_apply   = 1'b0;
      case (req_ff.mode)
         MODE_LOAD: begin
            if (dup_now) begin
               status_val = STATUS_DUPLICATE;
            end else if (!free_found_ff || q_full) begin
               status_val = STATUS_FULL;
            end else begin
               ok_apply = 1'b1;
            end
         end
         MODE_KILL: begin
            if (kill_hit) begin
               ok_apply = 1'b1;
            end else begin
               status_val = STATUS_NOT_FOUND;
            end
         end
         MODE_QUANTUM, MODE_RETIRE, MODE_DISPATCH: begin
            if (q_empty) begin
               status_val = STATUS_EMPTY;
            end else begin
               ok_apply = 1'b1;
            end
         end
         default: begin
            status_val = STATUS_OK;
         end
      endcase
   end

   assign do_apply = cmd.commit && ok_apply;
   assign cnt_next = (cnt_rd_ff == '1) ? cnt_rd_ff : cnt_rd_ff + 1'b1;

   // head and count updates
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (do_apply) begin
         case (req_ff.mode)
            MODE_LOAD: begin
               count_in = count_ff + 1'b1;
            end
            MODE_KILL: begin
               count_in = count_ff - 1'b1;
            end
            MODE_QUANTUM: begin
               head_in = ptr_inc(head_ff);
            end
            MODE_RETIRE: begin
               head_in  = ptr_inc(head_ff);
               count_in = count_ff - 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // build the response
   always_comb begin
      rsp_in              = '0;
      rsp_in.status       = status_val;
      rsp_in.queue_length = QLEN_W'(count_in);
      if (req_ff.mode == MODE_DISPATCH && ok_apply) begin
         rsp_in.run_valid = 1'b1;
         rsp_in.run_slot  = ID_W'(head_slot);
         rsp_in.run_count = cnt_next;
         if (head_fresh) begin
            rsp_in.run_address = start_rd_ff;
         end else begin
            rsp_in.run_address   = resume_rd_ff;
            rsp_in.run_resume    = 1'b1;
            rsp_in.run_work_byte = work_rd_ff;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // status to the controller
   assign sts.mode      = req_ff.mode;
   assign sts.q_empty   = q_empty;
   assign sts.kill_hit  = kill_hit;
   assign sts.scan_last = (sc_ff == SW'(SLOTS - 1));
   assign sts.walk_done = (wk_left_ff == '0) && !chk_vld_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // slot 0 is never handed out
   a_free_nonzero: assert property (@(posedge clock) disable iff (reset)
      free_found_ff |-> (free_slot_ff != '0))
      else $error("free slot search returned slot zero");

   // a kill that commits must have located its entry in the queue
   a_kill_found: assert property (@(posedge clock) disable iff (reset)
      (do_apply && req_ff.mode == MODE_KILL) |-> found_ff)
      else $error("kill committed without locating its queue entry");

   // walk shifting and commit never share the queue write port
   a_write_port: assert property (@(posedge clock) disable iff (reset)
      !(shift_we && do_apply))
      else $error("queue shift collides with commit");

   // retiring the head drops the queue length by one
   a_retire_count: assert property (@(posedge clock) disable iff (reset)
      (do_apply && req_ff.mode == MODE_RETIRE) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("retire did not shorten the queue");

endmodule
